/* src/cds_pkg.sv */
// cds_pkg: shared types, constants and the month length function
// for the calendar date stepper; no dependencies
package cds_pkg;

  localparam int DayW   = 5;
  localparam int MonthW = 4;
  localparam int YearW  = 14;

  localparam logic [YearW-1:0] MaxYear = 14'd9999;

  // year / 100 as (year * 5243) >> 19, exact for every 14-bit year
  localparam int Div100Mul   = 5243;
  localparam int Div100Shift = 19;
  localparam int ProdW       = 27;
  localparam int QuotW       = ProdW - Div100Shift;

  localparam logic [MonthW-1:0] MonthJan = 4'd1;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;
  localparam logic [DayW-1:0]   DayFirst = 5'd1;
  localparam logic [DayW-1:0]   DayLast  = 5'd31;

  typedef struct packed {
    logic              func;
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
  } date_t;

  // date after the leap test
  typedef struct packed {
    logic  vld;
    date_t date;
    logic  leap;
  } leap_stage_t;

  typedef struct packed {
    logic [DayW-1:0]   day;
    logic [MonthW-1:0] month;
    logic [YearW-1:0]  year;
    logic              leap;
    logic              valid;
  } result_t;

  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                 input logic leap);
    logic [DayW-1:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* src/calendar_date_stepper_top.sv */
// calendar_date_stepper_top: gregorian next / previous day stepper
// throughput: one item per cycle; start reaches done through the stage a, stage b and output registers
// stages: divide by 100 (constant multiply), leap rule, validity and step
// busy is never raised, so every start is taken; done cannot be held off
// rst (synchronous) clears the valid bits of all three stages
// depends on cds_pkg, cds_leap, cds_step
module calendar_date_stepper_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          func,
  input  logic [cds_pkg::DayW-1:0]      in_day,
  input  logic [cds_pkg::MonthW-1:0]    in_month,
  input  logic [cds_pkg::YearW-1:0]     in_year,
  output logic                          done,
  output logic [cds_pkg::DayW-1:0]      out_day,
  output logic [cds_pkg::MonthW-1:0]    out_month,
  output logic [cds_pkg::YearW-1:0]     out_year,
  output logic                          is_leap,
  output logic                          in_valid
);

  cds_pkg::date_t       date_in;
  cds_pkg::leap_stage_t leap_stage;
  cds_pkg::result_t     res;
  logic                 accept;

  // the pipeline never stalls, so an item is taken on every start
  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign date_in.func  = func;
  assign date_in.day   = in_day;
  assign date_in.month = in_month;
  assign date_in.year  = in_year;

  // first two stages: year / 100 and the leap flag
  cds_leap u_leap (
    .clk       (clk),
    .rst       (rst),
    .vld_in    (accept),
    .date_in   (date_in),
    .stage_out (leap_stage)
  );

  // last stage: month length, validity and the step itself
  cds_step u_step (
    .clk      (clk),
    .rst      (rst),
    .stage_in (leap_stage),
    .vld_out  (done),
    .res_out  (res)
  );

  assign out_day   = res.day;
  assign out_month = res.month;
  assign out_year  = res.year;
  assign is_leap   = res.leap;
  assign in_valid  = res.valid;

  // every accepted item comes out on done; no item is lost in the pipeline
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##3 done)
    else $error("item lost in pipeline");

  // a result always names a real month and day
  a_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (out_month >= cds_pkg::MonthJan) && (out_month <= cds_pkg::MonthDec) &&
             (out_day != '0) && (out_year <= cds_pkg::MaxYear))
    else $error("result date out of range");

  // an invalid date maps to the first of january
  a_invalid: assert property (@(posedge clk) disable iff (rst)
    (done && !in_valid) |-> (out_day == cds_pkg::DayFirst) &&
                            (out_month == cds_pkg::MonthJan))
    else $error("invalid date not mapped to january first");

endmodule

/* src/cds_leap.sv */
// cds_leap: two register stages that find the gregorian leap flag
// depends on cds_pkg
module cds_leap (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 vld_in,
  input  cds_pkg::date_t       date_in,
  output cds_pkg::leap_stage_t stage_out
);

  logic                                  vld_a;
  cds_pkg::date_t                        date_a;
  logic [cds_pkg::QuotW-1:0]             quot_a;
  logic [cds_pkg::ProdW-1:0]             prod;
  logic [cds_pkg::YearW-1:0]             rem100;
  logic                                  leap_next;
  cds_pkg::leap_stage_t                  stage;

  // stage a: quotient by 100 through a constant multiply
  assign prod = cds_pkg::ProdW'(date_in.year) * cds_pkg::ProdW'(cds_pkg::Div100Mul);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
    end else begin
      vld_a <= vld_in;
    end
    date_a <= date_in;
    quot_a <= prod[cds_pkg::ProdW-1:cds_pkg::Div100Shift];
  end

  // stage b: remainder by 100, then the leap rule
  assign rem100 = date_a.year - cds_pkg::YearW'(quot_a) * 14'd100;
  assign leap_next = (rem100 == '0) ? (quot_a[1:0] == 2'b00)
                                    : (date_a.year[1:0] == 2'b00);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.vld <= 1'b0;
    end else begin
      stage.vld <= vld_a;
    end
    stage.date <= date_a;
    stage.leap <= leap_next;
  end

  assign stage_out = stage;

endmodule

/* src/cds_step.sv */
// cds_step: validity check and the day step, with the output register
// depends on cds_pkg
module cds_step (
  input  logic                 clk,
  input  logic                 rst,
  input  cds_pkg::leap_stage_t stage_in,
  output logic                 vld_out,
  output cds_pkg::result_t     res_out
);

  logic [cds_pkg::DayW-1:0]   len;
  logic [cds_pkg::DayW-1:0]   prev_len;
  logic                       valid;
  logic                       vld;
  cds_pkg::date_t             d;
  cds_pkg::result_t           res;
  cds_pkg::result_t           res_next;

  assign d        = stage_in.date;
  assign len      = cds_pkg::month_len(d.month, stage_in.leap);
  assign prev_len = cds_pkg::month_len(d.month - 4'd1, stage_in.leap);
  assign valid    = (d.month >= cds_pkg::MonthJan) && (d.month <= cds_pkg::MonthDec) &&
                    (d.year <= cds_pkg::MaxYear) && (d.day != '0) && (d.day <= len);

  always_comb begin
    res_next.day   = d.day;
    res_next.month = d.month;
    res_next.year  = d.year;
    res_next.leap  = stage_in.leap;
    res_next.valid = valid;
    if (!valid) begin
      res_next.day   = cds_pkg::DayFirst;
      res_next.month = cds_pkg::MonthJan;
      res_next.year  = (d.year > cds_pkg::MaxYear) ? cds_pkg::MaxYear : d.year;
    end else if (!d.func) begin
      if (d.day < len) begin
        res_next.day = d.day + 5'd1;
      end else if (d.month < cds_pkg::MonthDec) begin
        res_next.day   = cds_pkg::DayFirst;
        res_next.month = d.month + 4'd1;
      end else if (d.year < cds_pkg::MaxYear) begin
        res_next.day   = cds_pkg::DayFirst;
        res_next.month = cds_pkg::MonthJan;
        res_next.year  = d.year + 14'd1;
      end
    end else begin
      if (d.day > cds_pkg::DayFirst) begin
        res_next.day = d.day - 5'd1;
      end else if (d.month > cds_pkg::MonthJan) begin
        res_next.day   = prev_len;
        res_next.month = d.month - 4'd1;
      end else if (d.year != '0) begin
        res_next.day   = cds_pkg::DayLast;
        res_next.month = cds_pkg::MonthDec;
        res_next.year  = d.year - 14'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      vld <= stage_in.vld;
    end
    res <= res_next;
  end

  assign vld_out = vld;
  assign res_out = res;

endmodule

/* verif/calendar_date_stepper_top_tb.sv */
// calendar_date_stepper_top_tb: self-checking bench for the gregorian day stepper
// directed date table then weighted random dates, scored by an in-bench predictor
// depends on cds_pkg and calendar_date_stepper_top
`timescale 1ns / 1ps

module calendar_date_stepper_top_tb;

  localparam int RandomItems   = 1750;
  localparam int WatchdogLimit = 2000;
  localparam int DrainCycles   = 8;     // idle clocks after the last result, before the verdict
  localparam int GapPercent    = 27;

  // one row of the directed table; typed rows carry a hand-written answer
  typedef struct {
    logic                       back;
    logic [cds_pkg::DayW-1:0]   day;
    logic [cds_pkg::MonthW-1:0] month;
    logic [cds_pkg::YearW-1:0]  year;
    logic                       typed;
    cds_pkg::result_t           want;
  } date_row_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic                       func = 1'b0;
  logic [cds_pkg::DayW-1:0]   in_day = '0;
  logic [cds_pkg::MonthW-1:0] in_month = '0;
  logic [cds_pkg::YearW-1:0]  in_year = '0;
  logic                       done;
  logic [cds_pkg::DayW-1:0]   out_day;
  logic [cds_pkg::MonthW-1:0] out_month;
  logic [cds_pkg::YearW-1:0]  out_year;
  logic                       is_leap;
  logic                       in_valid;

  // travels with the item so the monitor knows which answer to queue
  logic                       use_typed = 1'b0;
  cds_pkg::result_t           typed_want = '0;

  cds_pkg::result_t           expected_dates[$];
  date_row_t                  date_table[$];
  int                         mismatches = 0;
  int                         idle_cycles = 0;
  bit                         allow_gaps = 1'b1;

  calendar_date_stepper_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .func      (func),
    .in_day    (in_day),
    .in_month  (in_month),
    .in_year   (in_year),
    .done      (done),
    .out_day   (out_day),
    .out_month (out_month),
    .out_year  (out_year),
    .is_leap   (is_leap),
    .in_valid  (in_valid)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // divisible by 4 and not by 100, or divisible by 400; applied to all 14 bits
  function automatic logic is_gregorian_leap(input logic [cds_pkg::YearW-1:0] y);
    int unsigned yi;
    yi = y;
    return (yi % 400 == 0) || ((yi % 100 != 0) && (yi % 4 == 0));
  endfunction

  // out-of-range months fall to 31 here, but they never pass the validity test
  function automatic logic [cds_pkg::DayW-1:0] days_in_month(
      input logic [cds_pkg::MonthW-1:0] m, input logic leap);
    logic [cds_pkg::DayW-1:0] n;
    case (m)
      4'd2: begin
        n = leap ? 5'd29 : 5'd28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        n = 5'd30;
      end
      default: begin
        n = 5'd31;
      end
    endcase
    return n;
  endfunction

  function automatic cds_pkg::result_t step_date(input logic back,
                                                 input logic [cds_pkg::DayW-1:0] d,
                                                 input logic [cds_pkg::MonthW-1:0] m,
                                                 input logic [cds_pkg::YearW-1:0] y);
    cds_pkg::result_t         r;
    logic                     leap;
    logic [cds_pkg::DayW-1:0] len;
    logic                     real_date;
    leap = is_gregorian_leap(y);
    len = days_in_month(m, leap);
    real_date = (m >= cds_pkg::MonthJan) && (m <= cds_pkg::MonthDec) &&
                (y <= cds_pkg::MaxYear) && (d >= cds_pkg::DayFirst) && (d <= len);
    r.day = d;
    r.month = m;
    r.year = y;
    r.leap = leap;
    r.valid = real_date;
    if (!real_date) begin
      // bad dates collapse to jan 1 of the (saturated) year
      r.day = cds_pkg::DayFirst;
      r.month = cds_pkg::MonthJan;
      r.year = (y > cds_pkg::MaxYear) ? cds_pkg::MaxYear : y;
    end else if (!back) begin
      if (d < len) begin
        r.day = d + cds_pkg::DayFirst;
      end else if (m < cds_pkg::MonthDec) begin
        r.day = cds_pkg::DayFirst;
        r.month = m + cds_pkg::MonthJan;
      end else if (y < cds_pkg::MaxYear) begin
        r.day = cds_pkg::DayFirst;
        r.month = cds_pkg::MonthJan;
        r.year = y + 14'd1;
      end
      // 31.12.9999 forward stays put
    end else begin
      if (d > cds_pkg::DayFirst) begin
        r.day = d - cds_pkg::DayFirst;
      end else if (m > cds_pkg::MonthJan) begin
        r.month = m - cds_pkg::MonthJan;
        r.day = days_in_month(m - cds_pkg::MonthJan, leap);
      end else if (y != '0) begin
        r.day = cds_pkg::DayLast;
        r.month = cds_pkg::MonthDec;
        r.year = y - 14'd1;
      end
      // 01.01.0000 backward stays put
    end
    return r;
  endfunction

  function automatic cds_pkg::result_t date_result(input logic [cds_pkg::DayW-1:0] d,
                                                   input logic [cds_pkg::MonthW-1:0] m,
                                                   input logic [cds_pkg::YearW-1:0] y,
                                                   input logic leap,
                                                   input logic real_date);
    cds_pkg::result_t r;
    r.day = d;
    r.month = m;
    r.year = y;
    r.leap = leap;
    r.valid = real_date;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: queue on accept, score on done, watchdog on silence
  // ---------------------------------------------------------------------------

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    cds_pkg::result_t head;
    bit               moved;
    moved = 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        // typed rows override the predictor; everything else is predicted
        expected_dates.push_back(use_typed ? typed_want :
                                 step_date(func, in_day, in_month, in_year));
        moved = 1'b1;
      end
      if (done) begin
        moved = 1'b1;
        if (expected_dates.size() == 0) begin
          $error("result with no item outstanding: %0d.%0d.%0d",
                 out_day, out_month, out_year);
          mismatches++;
        end else begin
          head = expected_dates.pop_front();
          compare_field("out_day", head.day, out_day);
          compare_field("out_month", head.month, out_month);
          compare_field("out_year", head.year, out_year);
          compare_field("is_leap", head.leap, is_leap);
          compare_field("in_valid", head.valid, in_valid);
        end
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("calendar_date_stepper_top_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // driver
  // ---------------------------------------------------------------------------

  task automatic add_row(input logic back, input logic [cds_pkg::DayW-1:0] d,
                         input logic [cds_pkg::MonthW-1:0] m,
                         input logic [cds_pkg::YearW-1:0] y,
                         input logic typed, input cds_pkg::result_t want);
    date_row_t row;
    row.back = back;
    row.day = d;
    row.month = m;
    row.year = y;
    row.typed = typed;
    row.want = want;
    date_table.push_back(row);
  endtask

  // start stays high across back-to-back items; only a gap lowers it
  task automatic send_date(input logic back, input logic [cds_pkg::DayW-1:0] d,
                           input logic [cds_pkg::MonthW-1:0] m,
                           input logic [cds_pkg::YearW-1:0] y,
                           input logic typed, input cds_pkg::result_t want);
    while (allow_gaps && ($urandom_range(99) < GapPercent)) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    func <= back;
    in_day <= d;
    in_month <= m;
    in_year <= y;
    use_typed <= typed;
    typed_want <= want;
    do @(posedge clk); while (busy);
  endtask

  initial begin
    logic                       back;
    logic [cds_pkg::DayW-1:0]   d;
    logic [cds_pkg::MonthW-1:0] m;
    logic [cds_pkg::YearW-1:0]  y;
    logic [cds_pkg::DayW-1:0]   len;
    int                         pick;

    // directed table: edges of the calendar, leap rules, bad dates
    // calendar ends hold still going outward and step inward the other way
    add_row(1'b0, 5'd31, 4'd12, 14'd9999, 1'b1,
            date_result(5'd31, 4'd12, 14'd9999, 1'b0, 1'b1));
    add_row(1'b1, 5'd1, 4'd1, 14'd0, 1'b1,
            date_result(5'd1, 4'd1, 14'd0, 1'b1, 1'b1));
    add_row(1'b1, 5'd31, 4'd12, 14'd9999, 1'b0, '0);
    add_row(1'b0, 5'd1, 4'd1, 14'd0, 1'b0, '0);
    // bad dates: month out of range, day zero, day past month end, year too big
    add_row(1'b0, 5'd15, 4'd0, 14'd2023, 1'b1,
            date_result(5'd1, 4'd1, 14'd2023, 1'b0, 1'b0));
    add_row(1'b1, 5'd1, 4'd13, 14'd0, 1'b1,
            date_result(5'd1, 4'd1, 14'd0, 1'b1, 1'b0));
    add_row(1'b1, 5'd31, 4'd15, 14'd16383, 1'b1,
            date_result(5'd1, 4'd1, 14'd9999, 1'b0, 1'b0));
    add_row(1'b0, 5'd0, 4'd5, 14'd2024, 1'b1,
            date_result(5'd1, 4'd1, 14'd2024, 1'b1, 1'b0));
    add_row(1'b0, 5'd31, 4'd4, 14'd2023, 1'b1,
            date_result(5'd1, 4'd1, 14'd2023, 1'b0, 1'b0));
    add_row(1'b1, 5'd29, 4'd2, 14'd1900, 1'b1,
            date_result(5'd1, 4'd1, 14'd1900, 1'b0, 1'b0));
    add_row(1'b0, 5'd1, 4'd1, 14'd10000, 1'b1,
            date_result(5'd1, 4'd1, 14'd9999, 1'b1, 1'b0));
    // february across the leap rules
    add_row(1'b0, 5'd29, 4'd2, 14'd2000, 1'b0, '0);
    add_row(1'b1, 5'd29, 4'd2, 14'd2024, 1'b0, '0);
    add_row(1'b0, 5'd28, 4'd2, 14'd2023, 1'b0, '0);
    add_row(1'b1, 5'd1, 4'd3, 14'd2024, 1'b0, '0);
    add_row(1'b1, 5'd1, 4'd3, 14'd2100, 1'b0, '0);
    // year and month rollovers, 30/31-day months incl. july
    add_row(1'b0, 5'd31, 4'd12, 14'd1999, 1'b0, '0);
    add_row(1'b1, 5'd1, 4'd1, 14'd2000, 1'b0, '0);
    add_row(1'b0, 5'd30, 4'd4, 14'd2021, 1'b0, '0);
    add_row(1'b0, 5'd31, 4'd7, 14'd2021, 1'b0, '0);
    add_row(1'b1, 5'd1, 4'd8, 14'd2021, 1'b0, '0);
    add_row(1'b1, 5'd30, 4'd6, 14'd9999, 1'b0, '0);
    add_row(1'b0, 5'd31, 4'd1, 14'd0, 1'b0, '0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (date_table[i]) begin
      send_date(date_table[i].back, date_table[i].day, date_table[i].month,
                date_table[i].year, date_table[i].typed, date_table[i].want);
    end

    for (int n = 0; n < RandomItems; n++) begin
      // a long back-to-back stretch in the middle of the run
      allow_gaps = !(n >= 700 && n < 1000);
      back = 1'($urandom_range(1));
      pick = $urandom_range(9);
      case (pick)
        0: begin
          y = cds_pkg::YearW'($urandom_range(99) * 100);
        end
        1: begin
          y = cds_pkg::YearW'($urandom_range(24) * 400);
        end
        2: begin
          y = cds_pkg::YearW'($urandom_range(2499) * 4);
        end
        3: begin
          y = $urandom_range(1) ? cds_pkg::MaxYear : '0;
        end
        default: begin
          y = cds_pkg::YearW'($urandom_range(9999));
        end
      endcase
      m = cds_pkg::MonthW'($urandom_range(12, 1));
      len = days_in_month(m, is_gregorian_leap(y));
      // month ends and firsts get extra weight
      pick = $urandom_range(9);
      if (pick < 3) begin
        d = len;
      end else if (pick == 3) begin
        d = cds_pkg::DayFirst;
      end else begin
        d = cds_pkg::DayW'($urandom_range(len, 1));
      end
      // roughly one item in seven is broken in some way
      if ($urandom_range(99) >= 85) begin
        case ($urandom_range(4))
          0: begin
            m = $urandom_range(1) ? 4'd0 : 4'($urandom_range(15, 13));
          end
          1: begin
            d = '0;
          end
          2: begin
            d = (len < cds_pkg::DayLast) ? 5'($urandom_range(31, len + 1)) : '0;
          end
          3: begin
            y = cds_pkg::YearW'($urandom_range(16383, 10000));
          end
          default: begin
            {back, d, m, y} = 24'($urandom);
          end
        endcase
      end
      send_date(back, d, m, y, 1'b0, '0);
    end

    start <= 1'b0;
    // the watchdog covers a result that never shows up
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatches == 0) begin
      $display("calendar_date_stepper_top_tb: PASS");
    end else begin
      $display("calendar_date_stepper_top_tb: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
src/cds_pkg.sv
src/cds_leap.sv
src/cds_step.sv
src/calendar_date_stepper_top.sv
verif/calendar_date_stepper_top_tb.sv
